@@ hw/rtl/object_header_tree_parser_assert.svh @@
// Assertion macros for the checker file of the object header parser.
// Depends on nothing; each macro takes its own clock and active-low reset.
`ifndef OBJECT_HEADER_TREE_PARSER_ASSERT_SVH
`define OBJECT_HEADER_TREE_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define OHTP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ohtp same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define OHTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ohtp next-cycle check failed");

`endif

@@ hw/rtl/ohtp_pkg.sv @@
// Package for the object header and tree parser: item types, codes, helpers.
// Used by ohtp_step, object_header_tree_parser, ohtp_checker and the testbench.
package ohtp_pkg;

    localparam int HASH_BYTES_DEF = 32;
    localparam int SIZE_BITS_DEF  = 32;

    // Results one item can cause, and the index width over them.
    localparam int RES_MAX = 3;
    localparam int RES_IW  = 2;

    // Parser phases.
    localparam logic [2:0] PH_TYPE = 3'd0;
    localparam logic [2:0] PH_SIZE = 3'd1;
    localparam logic [2:0] PH_PASS = 3'd2;
    localparam logic [2:0] PH_MODE = 3'd3;
    localparam logic [2:0] PH_NAME = 3'd4;
    localparam logic [2:0] PH_HASH = 3'd5;
    localparam logic [2:0] PH_ERR  = 3'd6;

    // Result kinds.
    localparam logic [2:0] KIND_TYPE    = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_MODE    = 3'd2;
    localparam logic [2:0] KIND_NAME    = 3'd3;
    localparam logic [2:0] KIND_HASH    = 3'd4;
    localparam logic [2:0] KIND_DONE    = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_NUL    = 3'd1;
    localparam logic [2:0] ERR_NO_SPACE  = 3'd2;
    localparam logic [2:0] ERR_BAD_SIZE  = 3'd3;
    localparam logic [2:0] ERR_MISMATCH  = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    // Type match positions: 0..4 matched prefix of "tree", then no match.
    localparam logic [2:0] TYPE_FULL     = 3'd4;
    localparam logic [2:0] TYPE_NO_MATCH = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_object;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_char;
        logic        entry_end;
        logic [2:0]  error_code;
        logic [31:0] object_size;
        logic        tree_flag;
        logic        last;
    } t_out;

    // Narrow parser control state handed between the top level and the step logic.
    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] type_pos;
        logic       is_tree;
        logic       size_ovf;
        logic       digit_seen;
        logic       err_latched;
        logic       entry_open;
    } t_ctl;

    function automatic logic [7:0] tree_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h74;  // t
            3'd1:    c = 8'h72;  // r
            3'd2:    c = 8'h65;  // e
            3'd3:    c = 8'h65;  // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = 8'h30 + {4'd0, v};
        end else begin
            c = 8'h57 + {4'd0, v};
        end
        return c;
    endfunction

    function automatic t_out make_out(input logic [2:0] kind, input logic [7:0] ch,
                                      input logic ee, input logic [2:0] err,
                                      input logic [31:0] osize, input logic tflag);
        t_out r;
        r.kind        = kind;
        r.out_char    = ch;
        r.entry_end   = ee;
        r.error_code  = err;
        r.object_size = osize;
        r.tree_flag   = tflag;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

@@ hw/rtl/object_header_tree_parser.sv @@
// Top level of the object header and tree parser: input register, step logic, result buffer.
// Depends on ohtp_pkg and ohtp_step.
//
//  channel | valid       | stall       | payload            | items
//  --------+-------------+-------------+--------------------+------------------------------
//  in      | i_in_valid  | o_in_stall  | i_in  (t_in)       | one raw object byte + end mark
//  out     | o_out_valid | i_out_stall | o_out (t_out)      | one parser result
//
// An accepted byte is held in the input register, then the step logic turns it
// into zero to three results that load the result buffer together.
// The buffer shows one result per cycle unless the output stalls; a hash byte gives
// two results (two hex characters), and a byte with no results never waits for the
// buffer. A new batch loads as the previous batch's last result is taken.
// A stalled output holds the buffer; a held byte with results then waits in the input register and o_in_stall rises.
// Reset is synchronous and active low; it clears the parser state and both valid flags.
module object_header_tree_parser
    import ohtp_pkg::*;
#(
    parameter int HASH_BYTES = HASH_BYTES_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int HC_W = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;

    // Input register.
    logic r_in_valid;
    t_in  r_in;

    // Parser state.
    t_ctl                 r_ctl;
    logic [SIZE_BITS-1:0] r_acc;
    logic [SIZE_BITS-1:0] r_pcnt;
    logic [HC_W-1:0]      r_hcnt;

    // Next state from the step logic.
    t_ctl                 n_ctl;
    logic [SIZE_BITS-1:0] n_acc;
    logic [SIZE_BITS-1:0] n_pcnt;
    logic [HC_W-1:0]      n_hcnt;
    logic [RES_IW-1:0]    n_cnt;
    t_out                 n_res [RES_MAX];

    // Result buffer: up to three results of one byte, drained in order.
    t_out              r_res [RES_MAX];
    logic [RES_IW-1:0] r_cnt;
    logic [RES_IW-1:0] r_idx;

    logic out_pop;
    logic buf_free;
    logic step_go;

    ohtp_step #(
        .HASH_BYTES (HASH_BYTES),
        .SIZE_BITS  (SIZE_BITS)
    ) u_step (
        .i_item (r_in),
        .i_ctl  (r_ctl),
        .i_acc  (r_acc),
        .i_pcnt (r_pcnt),
        .i_hcnt (r_hcnt),
        .o_ctl  (n_ctl),
        .o_acc  (n_acc),
        .o_pcnt (n_pcnt),
        .o_hcnt (n_hcnt),
        .o_cnt  (n_cnt),
        .o_res  (n_res)
    );

    assign o_out_valid = (r_cnt != '0);
    assign o_out       = r_res[r_idx];
    assign out_pop     = o_out_valid && !i_out_stall;

    // The buffer can take a new batch when empty or when its final result leaves now.
    assign buf_free = (r_cnt == '0) || (out_pop && (r_idx == r_cnt - RES_IW'(1)));

    // A byte with no results never waits for the buffer.
    assign step_go    = r_in_valid && ((n_cnt == '0) || buf_free);
    assign o_in_stall = r_in_valid && !step_go;

    // Advance the input register whenever the held byte moves on or none is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in;
        end
    end

    // Commit the step's state update when the held byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_acc  <= '0;
            r_pcnt <= '0;
            r_hcnt <= '0;
        end else if (step_go) begin
            r_ctl  <= n_ctl;
            r_acc  <= n_acc;
            r_pcnt <= n_pcnt;
            r_hcnt <= n_hcnt;
        end
    end

    // Load a fresh batch, or step through the current one as results are taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (step_go && (n_cnt != '0)) begin
            r_cnt <= n_cnt;
            r_idx <= '0;
        end else if (out_pop) begin
            if (r_idx == r_cnt - RES_IW'(1)) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + RES_IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go && (n_cnt != '0)) begin
            r_res <= n_res;
        end
    end

endmodule

@@ hw/rtl/ohtp_step.sv @@
// Combinational step of the object header parser: one byte, state in, state and results out.
// Depends on ohtp_pkg.
module ohtp_step
    import ohtp_pkg::*;
#(
    parameter int HASH_BYTES = HASH_BYTES_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  t_in                                  i_item,
    input  t_ctl                                 i_ctl,
    input  logic [SIZE_BITS-1:0]                 i_acc,
    input  logic [SIZE_BITS-1:0]                 i_pcnt,
    input  logic [((HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1)-1:0] i_hcnt,
    output t_ctl                                 o_ctl,
    output logic [SIZE_BITS-1:0]                 o_acc,
    output logic [SIZE_BITS-1:0]                 o_pcnt,
    output logic [((HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1)-1:0] o_hcnt,
    output logic [RES_IW-1:0]                    o_cnt,
    output t_out                                 o_res [RES_MAX]
);

    localparam int HC_W = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;

    logic [7:0]           byte_in;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [SIZE_BITS+3:0] acc_w;
    logic [SIZE_BITS+3:0] acc_next_w;
    logic                 size_ovf_hit;
    logic                 pcnt_full;
    logic [HC_W:0]        hnext;
    logic                 hash_fin;
    logic [63:0]          size64;
    logic [2:0]           err;

    assign byte_in      = i_item.data_byte;
    assign is_digit     = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign digit        = byte_in[3:0];
    assign acc_w        = (SIZE_BITS + 4)'(i_acc);
    // acc * 10 + digit, checked against the field width
    assign acc_next_w   = (acc_w << 3) + (acc_w << 1) + (SIZE_BITS + 4)'(digit);
    assign size_ovf_hit = |acc_next_w[SIZE_BITS+3:SIZE_BITS];
    assign pcnt_full    = (i_pcnt == i_acc);
    assign hnext        = (HC_W + 1)'(i_hcnt) + (HC_W + 1)'(1);
    assign hash_fin     = (hnext >= (HC_W + 1)'(HASH_BYTES));

    always_comb begin
        o_ctl  = i_ctl;
        o_acc  = i_acc;
        o_pcnt = i_pcnt;
        o_hcnt = i_hcnt;
        o_cnt  = '0;
        err    = ERR_NONE;
        size64 = 64'(i_acc);
        for (int k = 0; k < RES_MAX; k++) begin
            o_res[k] = '0;
        end

        case (i_ctl.phase)
            PH_TYPE: begin
                if (byte_in == CH_SPACE) begin
                    o_ctl.is_tree = (i_ctl.type_pos == TYPE_FULL);
                    o_ctl.phase   = PH_SIZE;
                end else if (byte_in == CH_NUL) begin
                    err = ERR_NO_SPACE;
                end else begin
                    o_res[o_cnt] = make_out(KIND_TYPE, byte_in, 1'b0, ERR_NONE, '0, 1'b0);
                    o_cnt = o_cnt + RES_IW'(1);
                    if (i_ctl.type_pos < TYPE_FULL && byte_in == tree_char(i_ctl.type_pos)) begin
                        o_ctl.type_pos = i_ctl.type_pos + 3'd1;
                    end else begin
                        o_ctl.type_pos = TYPE_NO_MATCH;
                    end
                end
            end
            PH_SIZE: begin
                if (byte_in == CH_NUL) begin
                    if (!i_ctl.digit_seen || i_ctl.size_ovf) begin
                        err = ERR_BAD_SIZE;
                    end else begin
                        o_ctl.phase = i_ctl.is_tree ? PH_MODE : PH_PASS;
                        o_pcnt      = '0;
                    end
                end else if (is_digit) begin
                    o_ctl.digit_seen = 1'b1;
                    if (!i_ctl.size_ovf) begin
                        if (size_ovf_hit) begin
                            o_ctl.size_ovf = 1'b1;
                        end else begin
                            o_acc = acc_next_w[SIZE_BITS-1:0];
                        end
                    end
                end else begin
                    o_ctl.size_ovf = 1'b1;
                end
            end
            PH_ERR: begin
                // drop bytes until the end mark
            end
            default: begin
                if (pcnt_full) begin
                    err = ERR_MISMATCH;
                end else begin
                    o_pcnt = i_pcnt + SIZE_BITS'(1);
                    case (i_ctl.phase)
                        PH_PASS: begin
                            o_res[o_cnt] = make_out(KIND_PAYLOAD, byte_in, 1'b0, ERR_NONE,
                                                    '0, 1'b0);
                            o_cnt = o_cnt + RES_IW'(1);
                        end
                        PH_MODE: begin
                            o_ctl.entry_open = 1'b1;
                            if (byte_in == CH_SPACE) begin
                                o_ctl.phase = PH_NAME;
                            end else begin
                                o_res[o_cnt] = make_out(KIND_MODE, byte_in, 1'b0, ERR_NONE,
                                                        '0, 1'b0);
                                o_cnt = o_cnt + RES_IW'(1);
                            end
                        end
                        PH_NAME: begin
                            if (byte_in == CH_NUL) begin
                                o_ctl.phase = PH_HASH;
                                o_hcnt      = '0;
                            end else begin
                                o_res[o_cnt] = make_out(KIND_NAME, byte_in, 1'b0, ERR_NONE,
                                                        '0, 1'b0);
                                o_cnt = o_cnt + RES_IW'(1);
                            end
                        end
                        default: begin
                            o_res[o_cnt] = make_out(KIND_HASH, hex_char(byte_in[7:4]), 1'b0,
                                                    ERR_NONE, '0, 1'b0);
                            o_cnt = o_cnt + RES_IW'(1);
                            o_res[o_cnt] = make_out(KIND_HASH, hex_char(byte_in[3:0]),
                                                    hash_fin, ERR_NONE, '0, 1'b0);
                            o_cnt = o_cnt + RES_IW'(1);
                            if (hash_fin) begin
                                o_hcnt           = '0;
                                o_ctl.entry_open = 1'b0;
                                o_ctl.phase      = PH_MODE;
                            end else begin
                                o_hcnt = hnext[HC_W-1:0];
                            end
                        end
                    endcase
                end
            end
        endcase

        if (err != ERR_NONE) begin
            o_res[o_cnt] = make_out(KIND_ERROR, 8'h00, 1'b0, err, '0, 1'b0);
            o_cnt = o_cnt + RES_IW'(1);
            o_ctl.phase       = PH_ERR;
            o_ctl.err_latched = 1'b1;
        end

        if (i_item.end_of_object) begin
            if (!o_ctl.err_latched) begin
                if (o_ctl.phase == PH_TYPE || o_ctl.phase == PH_SIZE) begin
                    o_res[o_cnt] = make_out(KIND_ERROR, 8'h00, 1'b0, ERR_NO_NUL, '0, 1'b0);
                end else if (o_pcnt != o_acc) begin
                    o_res[o_cnt] = make_out(KIND_ERROR, 8'h00, 1'b0, ERR_MISMATCH, '0, 1'b0);
                end else if (o_ctl.phase != PH_PASS && o_ctl.entry_open) begin
                    o_res[o_cnt] = make_out(KIND_ERROR, 8'h00, 1'b0, ERR_TRUNCATED, '0,
                                            1'b0);
                end else begin
                    o_res[o_cnt] = make_out(KIND_DONE, 8'h00, 1'b0, ERR_NONE, size64[31:0],
                                            o_ctl.is_tree);
                end
                o_cnt = o_cnt + RES_IW'(1);
            end
            o_ctl  = '0;
            o_acc  = '0;
            o_pcnt = '0;
            o_hcnt = '0;
        end

        if (o_cnt != '0) begin
            o_res[o_cnt - RES_IW'(1)].last = 1'b1;
        end
    end

endmodule

@@ hw/rtl/ohtp_checker.sv @@
// Port-level checks for the object header parser, bound onto the top level.
// Depends on ohtp_pkg and object_header_tree_parser_assert.svh.
`include "object_header_tree_parser_assert.svh"

module ohtp_checker
    import ohtp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_stall,
    input t_out i_out
);

    // A stalled result holds.
    `OHTP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall,
                      i_out_valid && $stable(i_out))

    // An error code comes with an error result and only then.
    `OHTP_ASSERT_SAME(a_err_code, i_clk, i_rst_n, i_out_valid,
                      (i_out.kind == KIND_ERROR) == (i_out.error_code != ERR_NONE))

    // Entry end marks only a hash character.
    `OHTP_ASSERT_SAME(a_entry_end, i_clk, i_rst_n, i_out_valid && i_out.entry_end,
                      i_out.kind == KIND_HASH)

    // Done and error close the results of their byte.
    `OHTP_ASSERT_SAME(a_final_last, i_clk, i_rst_n,
                      i_out_valid && (i_out.kind == KIND_DONE || i_out.kind == KIND_ERROR),
                      i_out.last && (i_out.out_char == 8'h00))

endmodule

bind object_header_tree_parser ohtp_checker u_ohtp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

@@ sim/tb_object_header_tree_parser.sv @@
// Self-checking testbench for object_header_tree_parser: random and directed object streams.
// Depends on ohtp_pkg and the RTL of the parser; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module tb_object_header_tree_parser
    import ohtp_pkg::*;
();

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    // Input items to send in all, the directed part included.
    localparam int ITEM_TARGET  = 200;
    // Long receiver hold-off; it must outlast the parser's internal buffering.
    localparam int LONG_HOLD    = 300;
    // Cycles with no handshake on either side before the run is declared hung.
    localparam int IDLE_LIMIT   = 4000;
    // Settle time after the last expected result.
    localparam int TAIL_CYCLES  = 16;

    localparam longint unsigned SIZE_LIMIT = (64'd1 << SIZE_BITS_DEF) - 64'd1;
    localparam logic [31:0]     TREE_WORD  = "tree";

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    // Scoreboard: tracks the parser state per object and holds the results still due.
    class parse_scoreboard;
        t_out            pending_results[$];
        int              fail_count;
        int              sent_bytes;

        logic [2:0]      phase;
        logic [2:0]      type_pos;
        logic            is_tree;
        logic            size_bad;
        logic            digit_seen;
        logic            err_latched;
        logic            entry_open;
        longint unsigned size_acc;
        longint unsigned payload_cnt;
        int              hash_cnt;

        function new();
            fail_count = 0;
            sent_bytes = 0;
            clear_object();
        endfunction

        function void clear_object();
            phase       = PH_TYPE;
            type_pos    = 3'd0;
            is_tree     = 1'b0;
            size_bad    = 1'b0;
            digit_seen  = 1'b0;
            err_latched = 1'b0;
            entry_open  = 1'b0;
            size_acc    = 0;
            payload_cnt = 0;
            hash_cnt    = 0;
        endfunction

        function logic [7:0] hex_digit(logic [3:0] v);
            // Lowercase only: 'a' is 8'h61.
            return (v < 4'd10) ? CH_ZERO + 8'(v) : 8'h61 + 8'(v - 4'd10);
        endfunction

        function void add_result(logic [2:0] kind, logic [7:0] ch, logic ee, logic [2:0] err);
            t_out r;
            r.kind        = kind;
            r.out_char    = ch;
            r.entry_end   = ee;
            r.error_code  = err;
            r.object_size = (kind == KIND_DONE) ? size_acc[31:0] : 32'd0;
            r.tree_flag   = (kind == KIND_DONE) ? is_tree : 1'b0;
            r.last        = 1'b0;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Advance the parse by one accepted byte and queue the results it causes.
        function void note_byte(t_in it);
            logic [7:0]      b;
            logic [2:0]      err;
            logic            fin;
            int              first;
            int              nxt;
            longint unsigned d;
            b     = it.data_byte;
            err   = ERR_NONE;
            first = pending_results.size();
            sent_bytes++;
            case (phase)
                PH_TYPE: begin
                    if (b == CH_SPACE) begin
                        is_tree = (type_pos == TYPE_FULL);
                        phase   = PH_SIZE;
                    end else if (b == CH_NUL) begin
                        err = ERR_NO_SPACE;
                    end else begin
                        add_result(KIND_TYPE, b, 1'b0, ERR_NONE);
                        if (type_pos < TYPE_FULL &&
                            b == TREE_WORD[31 - 8*int'(type_pos) -: 8]) begin
                            type_pos = type_pos + 3'd1;
                        end else begin
                            type_pos = TYPE_NO_MATCH;
                        end
                    end
                end
                PH_SIZE: begin
                    if (b == CH_NUL) begin
                        if (!digit_seen || size_bad) begin
                            err = ERR_BAD_SIZE;
                        end else begin
                            phase       = is_tree ? PH_MODE : PH_PASS;
                            payload_cnt = 0;
                        end
                    end else if (b >= CH_ZERO && b <= CH_NINE) begin
                        d          = b - CH_ZERO;
                        digit_seen = 1'b1;
                        if (!size_bad) begin
                            if (size_acc > (SIZE_LIMIT - d) / 10) begin
                                size_bad = 1'b1;
                            end else begin
                                size_acc = size_acc * 10 + d;
                            end
                        end
                    end else begin
                        size_bad = 1'b1;
                    end
                end
                PH_ERR: ;
                default: begin
                    if (payload_cnt == size_acc) begin
                        err = ERR_MISMATCH;
                    end else begin
                        payload_cnt++;
                        case (phase)
                            PH_PASS: add_result(KIND_PAYLOAD, b, 1'b0, ERR_NONE);
                            PH_MODE: begin
                                entry_open = 1'b1;
                                if (b == CH_SPACE) begin
                                    phase = PH_NAME;
                                end else begin
                                    add_result(KIND_MODE, b, 1'b0, ERR_NONE);
                                end
                            end
                            PH_NAME: begin
                                if (b == CH_NUL) begin
                                    phase    = PH_HASH;
                                    hash_cnt = 0;
                                end else begin
                                    add_result(KIND_NAME, b, 1'b0, ERR_NONE);
                                end
                            end
                            default: begin
                                nxt = hash_cnt + 1;
                                fin = (nxt >= HASH_BYTES_DEF);
                                add_result(KIND_HASH, hex_digit(b[7:4]), 1'b0, ERR_NONE);
                                add_result(KIND_HASH, hex_digit(b[3:0]), fin, ERR_NONE);
                                if (fin) begin
                                    hash_cnt   = 0;
                                    entry_open = 1'b0;
                                    phase      = PH_MODE;
                                end else begin
                                    hash_cnt = nxt;
                                end
                            end
                        endcase
                    end
                end
            endcase

            if (err != ERR_NONE) begin
                add_result(KIND_ERROR, 8'h00, 1'b0, err);
                phase       = PH_ERR;
                err_latched = 1'b1;
            end

            if (it.end_of_object) begin
                if (!err_latched) begin
                    if (phase == PH_TYPE || phase == PH_SIZE) begin
                        add_result(KIND_ERROR, 8'h00, 1'b0, ERR_NO_NUL);
                    end else if (payload_cnt != size_acc) begin
                        add_result(KIND_ERROR, 8'h00, 1'b0, ERR_MISMATCH);
                    end else if (phase != PH_PASS && entry_open) begin
                        add_result(KIND_ERROR, 8'h00, 1'b0, ERR_TRUNCATED);
                    end else begin
                        add_result(KIND_DONE, 8'h00, 1'b0, ERR_NONE);
                    end
                end
                clear_object();
            end

            // Flag the final result of this byte.
            if (pending_results.size() > first) begin
                pending_results[pending_results.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d, char %0h", got.kind, got.out_char);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("out_char", want.out_char, got.out_char);
            check_field("entry_end", want.entry_end, got.entry_end);
            check_field("error_code", want.error_code, got.error_code);
            check_field("object_size", want.object_size, got.object_size);
            check_field("tree_flag", want.tree_flag, got.tree_flag);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_item   = '0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_item;

    parse_scoreboard sb = new();

    // Object under construction: header plus payload, and the payload on its own.
    logic [7:0] object_q[$];
    logic [7:0] payload_q[$];

    int burst_left   = 0;
    bit hold_off_req = 1'b0;

    object_header_tree_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Sample both handshakes at the edge; every value read here is the pre-edge one.
    // Note the input first: a result can never come from the byte accepted at the same edge.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            sb.note_byte(in_item);
        end
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_item);
        end
    end

    // Receiver: switch to a randomly chosen stall pattern when the current one runs out, and on request
    // hold off for a long stretch so the parser fills up and stalls its input.
    initial begin : receiver
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[object_header_tree_parser] ERROR");
        $finish;
    end

    // Append one byte to the object or to the payload.
    function automatic void obj_add(logic [7:0] b);
        object_q.insert(object_q.size(), b);
    endfunction

    function automatic void pay_add(logic [7:0] b);
        payload_q.insert(payload_q.size(), b);
    endfunction

    // Offer one byte in bursts of random length; hold it until the parser takes it.
    task automatic send_byte(input t_in it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Send the object built in object_q, end mark on its last byte, then drop it.
    task automatic send_object();
        t_in it;
        foreach (object_q[i]) begin
            it.data_byte     = object_q[i];
            it.end_of_object = (i == object_q.size() - 1);
            send_byte(it);
        end
        object_q.delete();
        payload_q.delete();
    endtask

    // Drop valid and wait until every queued result has come out; the queue is checked
    // only after waiting on the clock, so the last accepted byte is noted.
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    function automatic void push_str(string s);
        foreach (s[i]) obj_add(s[i]);
    endfunction

    function automatic logic [7:0] rand_byte_avoiding(logic [7:0] x, logic [7:0] y);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == x || b == y);
        return b;
    endfunction

    // Any byte that makes a size field bad: neither a digit nor NUL.
    function automatic logic [7:0] rand_non_digit();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_NUL || (b >= CH_ZERO && b <= CH_NINE));
        return b;
    endfunction

    // Type field: "blob", a near miss of "tree", or raw bytes (rarely "tree" by chance).
    function automatic void push_type();
        string near_tree[4] = '{"tre", "trees", "Tree", "tref"};
        case ($urandom_range(0, 3))
            0:       push_str("blob");
            1:       push_str(near_tree[$urandom_range(0, 3)]);
            default: repeat ($urandom_range(1, 5)) obj_add(rand_byte_avoiding(CH_SPACE, CH_NUL));
        endcase
    endfunction

    // One tree entry: mode up to a space, name up to a NUL, then the raw hash bytes.
    function automatic void add_entry();
        repeat ($urandom_range(1, 6)) begin
            pay_add(($urandom_range(0, 3) != 0) ? 8'(CH_ZERO + $urandom_range(0, 7))
                                                : rand_byte_avoiding(CH_SPACE, CH_SPACE));
        end
        pay_add(CH_SPACE);
        repeat ($urandom_range(1, 5)) pay_add(rand_byte_avoiding(CH_NUL, CH_NUL));
        pay_add(CH_NUL);
        repeat (HASH_BYTES_DEF) pay_add(8'($urandom_range(0, 255)));
    endfunction

    // Finish the header with the given size and append the payload.
    function automatic void close_header(longint unsigned size);
        obj_add(CH_SPACE);
        push_str($sformatf("%0d", size));
        obj_add(CH_NUL);
        foreach (payload_q[i]) obj_add(payload_q[i]);
    endfunction

    // Short directed part: field extremes and some corners of the header and payload checks.
    task automatic run_directed();
        // NUL in the type field, end mark on the same byte.
        obj_add(CH_NUL);
        send_object();
        // Object ends inside the type field.
        push_str("ab");
        send_object();
        // Plain payload passthrough with an all-ones byte.
        push_str("x 1");
        obj_add(CH_NUL);
        obj_add(8'hFF);
        send_object();
        // Empty tree.
        push_str("tree 0");
        obj_add(CH_NUL);
        send_object();
        // Non-digit in the size, empty type.
        push_str(" 1a");
        obj_add(CH_NUL);
        send_object();
        // Empty size.
        push_str(" ");
        obj_add(CH_NUL);
        send_object();
        // Payload byte beyond the declared size.
        push_str("t 0");
        obj_add(CH_NUL);
        obj_add(CH_NUL);
        send_object();
    endtask

    // Build and send one random object. Nearly half are well formed with random content;
    // the rest break the header or the payload in one specific way.
    task automatic random_object();
        int              pick;
        int              n;
        int              k;
        longint unsigned declared;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            // Well-formed tree, mostly one entry.
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 1;
            repeat (n) add_entry();
            push_str("tree");
            close_header(payload_q.size());
        end else if (pick < 47) begin
            // Well-formed non-tree object.
            push_type();
            repeat ($urandom_range(0, 6)) pay_add(8'($urandom_range(0, 255)));
            close_header(payload_q.size());
        end else if (pick < 57) begin
            // Tree whose size matches but whose last entry stops early.
            if ($urandom_range(0, 3) == 0) add_entry();
            n = payload_q.size();
            add_entry();
            k = $urandom_range(n + 1, payload_q.size() - 1);
            while (payload_q.size() > k) void'(payload_q.pop_back());
            push_str("tree");
            close_header(payload_q.size());
        end else if (pick < 65) begin
            // Payload shorter than declared, sometimes with the largest legal size.
            if ($urandom_range(0, 1) != 0) push_str("tree");
            else push_type();
            repeat ($urandom_range(0, 3)) pay_add(8'($urandom_range(0, 255)));
            declared = ($urandom_range(0, 3) == 0) ? SIZE_LIMIT
                                                   : payload_q.size() + $urandom_range(1, 3);
            close_header(declared);
        end else if (pick < 72) begin
            // Payload longer than declared; bytes after the error are dropped.
            push_type();
            repeat ($urandom_range(0, 3)) pay_add(8'($urandom_range(0, 255)));
            close_header(payload_q.size());
            repeat ($urandom_range(1, 2)) obj_add(8'($urandom_range(0, 255)));
        end else if (pick < 80) begin
            // Bad size field: stray character, overflow, or nothing at all.
            push_type();
            obj_add(CH_SPACE);
            case ($urandom_range(0, 2))
                0: begin
                    push_str($sformatf("%0d", $urandom_range(0, 99)));
                    obj_add(rand_non_digit());
                    push_str($sformatf("%0d", $urandom_range(0, 99)));
                end
                1: begin
                    if ($urandom_range(0, 1) != 0) push_str("4294967296");
                    else push_str($sformatf("%0d%0d", $urandom_range(42950, 99999),
                                            $urandom_range(100000, 999999)));
                end
                default: ;
            endcase
            obj_add(CH_NUL);
            repeat ($urandom_range(0, 2)) obj_add(8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
            // Object ends before the header NUL.
            if ($urandom_range(0, 1) != 0) push_str("tree");
            else push_type();
            obj_add(CH_SPACE);
            push_str($sformatf("%0d", $urandom_range(0, 50)));
            k = $urandom_range(1, object_q.size());
            while (object_q.size() > k) void'(object_q.pop_back());
        end else if (pick < 94) begin
            // NUL where the space should be.
            push_type();
            obj_add(CH_NUL);
            repeat ($urandom_range(0, 2)) obj_add(8'($urandom_range(0, 255)));
        end else begin
            // Raw noise.
            repeat ($urandom_range(1, 6)) obj_add(8'($urandom_range(0, 255)));
        end
        send_object();
    endtask

    initial begin : stimulus
        bit paused;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        // Hold the receiver off while the random part starts, so the parser backs up.
        hold_off_req = 1'b1;
        while (sb.sent_bytes < ITEM_TARGET) begin
            random_object();
            // Pause the sender once until the parser has emptied completely.
            if (!paused && sb.sent_bytes > ITEM_TARGET / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
            $display("[object_header_tree_parser] OK");
        end else begin
            $display("[object_header_tree_parser] ERROR");
        end
        $finish;
    end

endmodule
